// ----- hdl/dfs_pkg.sv -----
package dfs_pkg;

  localparam int MAX_FIELDS = 255;
  localparam int FIELD_CAP = (MAX_FIELDS > 255) ? 255 : ((MAX_FIELDS < 1) ? 1 : MAX_FIELDS);
  localparam logic [7:0] FIELD_LAST = 8'(FIELD_CAP - 1);

  localparam logic [7:0] QUOTE_BYTE = 8'd34;
  localparam logic [7:0] CR_BYTE = 8'd13;
  localparam logic [7:0] LF_BYTE = 8'd10;
  localparam logic [7:0] SEPARATOR_RESET = 8'd44;

  localparam logic [2:0] MODE_LINE_START = 3'd0;
  localparam logic [2:0] MODE_FIELD_START = 3'd1;
  localparam logic [2:0] MODE_UNQUOTED = 3'd2;
  localparam logic [2:0] MODE_QUOTED = 3'd3;
  localparam logic [2:0] MODE_QUOTE_SEEN = 3'd4;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END = 2'd2;

  localparam logic [7:0] REG_SEPARATOR_A = 8'd0;
  localparam logic [7:0] REG_SEPARATOR_B = 8'd1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } text_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [7:0] field_number;
  } result_item_t;

  typedef struct packed {
    logic [2:0] parse_mode;
    logic       after_carriage_return;
    logic [7:0] field_counter;
  } parser_state_t;

endpackage

// ----- hdl/dfs_step.sv -----
module dfs_step
  import dfs_pkg::*;
(
  input  parser_state_t state,
  input  text_item_t    item,
  input  logic [7:0]    separator_a,
  input  logic [7:0]    separator_b,
  output parser_state_t state_next,
  output logic          emit,
  output result_item_t  result
);

  logic       is_sep;
  logic [7:0] b;
  logic [7:0] line_count;
  logic [7:0] counter_inc;

  assign b = item.text_byte;
  assign is_sep = (b == separator_a) || (b == separator_b);
  assign line_count = (state.parse_mode == MODE_LINE_START) ? 8'd0
                                                            : state.field_counter + 8'd1;
  assign counter_inc = (state.field_counter < FIELD_LAST) ? state.field_counter + 8'd1
                                                          : state.field_counter;

  always_comb begin
    state_next = state;
    state_next.after_carriage_return = 1'b0;
    emit = 1'b0;
    result.kind = KIND_BYTE;
    result.value = 8'd0;
    result.field_number = state.field_counter;

    if (item.end_of_input) begin
      emit = (state.parse_mode != MODE_LINE_START);
      result.kind = KIND_LINE_END;
      result.field_number = line_count;
      state_next.parse_mode = MODE_LINE_START;
      state_next.field_counter = 8'd0;
    end else if (b == LF_BYTE && state.after_carriage_return) begin
      emit = 1'b0;
    end else if (b == CR_BYTE || b == LF_BYTE) begin
      emit = 1'b1;
      result.kind = KIND_LINE_END;
      result.field_number = line_count;
      state_next.parse_mode = MODE_LINE_START;
      state_next.field_counter = 8'd0;
      state_next.after_carriage_return = (b == CR_BYTE);
    end else begin
      case (state.parse_mode)
        MODE_LINE_START, MODE_FIELD_START: begin
          if (b == QUOTE_BYTE) begin
            state_next.parse_mode = MODE_QUOTED;
          end else if (is_sep) begin
            emit = 1'b1;
            result.kind = KIND_FIELD_END;
            state_next.field_counter = counter_inc;
            state_next.parse_mode = MODE_FIELD_START;
          end else begin
            emit = 1'b1;
            result.value = b;
            state_next.parse_mode = MODE_UNQUOTED;
          end
        end
        MODE_QUOTED: begin
          if (b == QUOTE_BYTE) begin
            state_next.parse_mode = MODE_QUOTE_SEEN;
          end else begin
            emit = 1'b1;
            result.value = b;
          end
        end
        MODE_QUOTE_SEEN: begin
          if (b == QUOTE_BYTE) begin
            emit = 1'b1;
            result.value = b;
            state_next.parse_mode = MODE_QUOTED;
          end else if (is_sep) begin
            emit = 1'b1;
            result.kind = KIND_FIELD_END;
            state_next.field_counter = counter_inc;
            state_next.parse_mode = MODE_FIELD_START;
          end else begin
            emit = 1'b1;
            result.value = b;
            state_next.parse_mode = MODE_UNQUOTED;
          end
        end
        default: begin
          emit = 1'b1;
          if (is_sep) begin
            result.kind = KIND_FIELD_END;
            state_next.field_counter = counter_inc;
            state_next.parse_mode = MODE_FIELD_START;
          end else begin
            result.value = b;
            state_next.parse_mode = MODE_UNQUOTED;
          end
        end
      endcase
    end
  end

endmodule

// ----- hdl/delimited_field_splitter.sv -----
// Splits a byte stream into fields and lines, one text byte per clock cycle when not
// stalled. Each accepted byte updates the parser state in the same cycle and, when it
// yields a content byte, a field end or a line end, that result appears on the result
// channel in the cycle after the transfer. The single result register is the only
// stage, and a new byte is taken whenever that register is empty or is being read
// out in the same cycle. The always-ready cfg channel writes the separator registers.
module delimited_field_splitter
  import dfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         text_valid,
  output logic         text_ready,
  input  text_item_t   text,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  logic [7:0]    separator_a;
  logic [7:0]    separator_b;
  parser_state_t state;
  parser_state_t state_next;
  logic          emit;
  result_item_t  step_result;
  logic          text_xfer;

  assign cfg_ready = 1'b1;
  assign text_ready = !result_valid || result_ready;
  assign text_xfer = text_valid && text_ready;

  dfs_step u_step (
    .state       (state),
    .item        (text),
    .separator_a (separator_a),
    .separator_b (separator_b),
    .state_next  (state_next),
    .emit        (emit),
    .result      (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_a <= SEPARATOR_RESET;
      separator_b <= SEPARATOR_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SEPARATOR_A) begin
        separator_a <= cfg_data;
      end else if (cfg_index == REG_SEPARATOR_B) begin
        separator_b <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.parse_mode <= MODE_LINE_START;
      state.after_carriage_return <= 1'b0;
      state.field_counter <= 8'd0;
      result_valid <= 1'b0;
    end else begin
      if (text_xfer) begin
        state <= state_next;
        result_valid <= emit;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_xfer && emit) begin
      result <= step_result;
    end
  end

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.kind == KIND_BYTE || result.kind == KIND_FIELD_END ||
                      result.kind == KIND_LINE_END))
    else $error("result kind outside the defined codes");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind != KIND_BYTE) |-> (result.value == 8'd0))
    else $error("nonzero value on a field or line end");

  a_counter_cap: assert property (@(posedge clk) disable iff (rst)
    state.field_counter <= FIELD_LAST)
    else $error("field counter beyond its cap");

  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    (text_xfer && emit && step_result.kind == KIND_LINE_END) |=>
      (state.parse_mode == MODE_LINE_START && state.field_counter == 8'd0))
    else $error("line end did not return parser to line start");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("pending result lost or changed");

endmodule

// ----- sim/delimited_field_splitter_tb.sv -----
module delimited_field_splitter_tb
  import dfs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 58;
  localparam int PHASES = 12;

  class split_tracker;
    logic [7:0] sep_a = SEPARATOR_RESET;
    logic [7:0] sep_b = SEPARATOR_RESET;
    logic [2:0] mode = MODE_LINE_START;
    logic cr_seen = 1'b0;
    logic [7:0] field_idx = 8'd0;
    result_item_t pending[$];
    int mismatches = 0;

    function void write_register(logic [7:0] index, logic [7:0] data);
      if (index == REG_SEPARATOR_A) begin
        sep_a = data;
      end else if (index == REG_SEPARATOR_B) begin
        sep_b = data;
      end
    endfunction

    function bit is_sep(logic [7:0] b);
      return b == sep_a || b == sep_b;
    endfunction

    function void push(logic [1:0] kind, logic [7:0] value, logic [7:0] number);
      result_item_t r;
      r.kind = kind;
      r.value = value;
      r.field_number = number;
      pending.insert(pending.size(), r);
    endfunction

    function void close_field();
      push(KIND_FIELD_END, 8'd0, field_idx);
      if (int'(field_idx) + 1 < FIELD_CAP) field_idx++;
      mode = MODE_FIELD_START;
    endfunction

    function void close_line();
      push(KIND_LINE_END, 8'd0, (mode == MODE_LINE_START) ? 8'd0 : field_idx + 8'd1);
      mode = MODE_LINE_START;
      field_idx = 8'd0;
    endfunction

    function void note_text(text_item_t t);
      logic [7:0] b;
      logic prev_cr;
      b = t.text_byte;
      prev_cr = cr_seen;
      cr_seen = 1'b0;
      if (t.end_of_input) begin
        if (mode != MODE_LINE_START) close_line();
        mode = MODE_LINE_START;
        field_idx = 8'd0;
        return;
      end
      if (b == LF_BYTE && prev_cr) return;
      if (b == CR_BYTE || b == LF_BYTE) begin
        cr_seen = (b == CR_BYTE);
        close_line();
        return;
      end
      case (mode)
        MODE_LINE_START, MODE_FIELD_START: begin
          if (b == QUOTE_BYTE) begin
            mode = MODE_QUOTED;
          end else if (is_sep(b)) begin
            close_field();
          end else begin
            mode = MODE_UNQUOTED;
            push(KIND_BYTE, b, field_idx);
          end
        end
        MODE_QUOTED: begin
          if (b == QUOTE_BYTE) mode = MODE_QUOTE_SEEN;
          else push(KIND_BYTE, b, field_idx);
        end
        MODE_QUOTE_SEEN: begin
          if (b == QUOTE_BYTE) begin
            mode = MODE_QUOTED;
            push(KIND_BYTE, b, field_idx);
          end else if (is_sep(b)) begin
            close_field();
          end else begin
            mode = MODE_UNQUOTED;
            push(KIND_BYTE, b, field_idx);
          end
        end
        default: begin
          if (is_sep(b)) begin
            close_field();
          end else begin
            mode = MODE_UNQUOTED;
            push(KIND_BYTE, b, field_idx);
          end
        end
      endcase
    endfunction

    task report(string msg);
      if (mismatches < 100) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(result_item_t r);
      result_item_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result kind %0d value %0d field %0d",
                         r.kind, r.value, r.field_number));
        return;
      end
      want = pending.pop_front();
      if (r.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", r.kind, want.kind));
      if (r.value !== want.value)
        report($sformatf("value %0d, expected %0d", r.value, want.value));
      if (r.field_number !== want.field_number)
        report($sformatf("field_number %0d, expected %0d", r.field_number, want.field_number));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic text_valid = 1'b0;
  logic text_ready;
  text_item_t text = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_item_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = 8'd0;
  logic [7:0] cfg_data = 8'd0;

  split_tracker tracker = new;
  text_item_t stim_q[$];
  int send_idle_pct = 31;
  int recv_idle_pct = 82;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;

  delimited_field_splitter DUT (
    .clk(clk),
    .rst(rst),
    .text_valid(text_valid),
    .text_ready(text_ready),
    .text(text),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((text_valid && text_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // The receiver runs on its own; a requested hold-off is counted down here.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) tracker.check_result(result);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic text_item_t txt(logic [7:0] b, logic eoi);
    text_item_t t;
    t.text_byte = b;
    t.end_of_input = eoi;
    return t;
  endfunction

  function automatic void add_text(logic [7:0] b, logic eoi);
    stim_q.insert(stim_q.size(), txt(b, eoi));
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (tracker.is_sep(b) || b == QUOTE_BYTE || b == CR_BYTE || b == LF_BYTE)
      b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [7:0] pick_sep();
    return $urandom_range(1) ? tracker.sep_a : tracker.sep_b;
  endfunction

  function automatic void add_line();
    int nf;
    nf = $urandom_range(0, 6);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) add_text(pick_sep(), 1'b0);
      case ($urandom_range(3))
        0: ;
        1: repeat ($urandom_range(1, 5)) add_text(plain_byte(), 1'b0);
        default: begin
          add_text(QUOTE_BYTE, 1'b0);
          repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(9))
              0, 1: begin
                add_text(QUOTE_BYTE, 1'b0);
                add_text(QUOTE_BYTE, 1'b0);
              end
              2: add_text(pick_sep(), 1'b0);
              default: add_text(plain_byte(), 1'b0);
            endcase
          end
          add_text(QUOTE_BYTE, 1'b0);
          if ($urandom_range(9) < 3)
            repeat ($urandom_range(1, 3)) add_text(plain_byte(), 1'b0);
        end
      endcase
    end
    if (nf > 0 && $urandom_range(9) == 0) add_text(pick_sep(), 1'b0);
    case ($urandom_range(4))
      0: add_text(CR_BYTE, 1'b0);
      1: add_text(LF_BYTE, 1'b0);
      2, 3: begin
        add_text(CR_BYTE, 1'b0);
        add_text(LF_BYTE, 1'b0);
      end
      default: add_text(8'($urandom_range(255)), 1'b1);
    endcase
  endfunction

  task automatic run_queue();
    text_item_t item;
    while (stim_q.size() > 0) begin
      item = stim_q.pop_front();
      while ($urandom_range(99) < send_idle_pct) begin
        text_valid <= 1'b0;
        @(posedge clk);
      end
      text_valid <= 1'b1;
      text <= item;
      do @(posedge clk); while (!text_ready);
      tracker.note_text(item);
    end
    text_valid <= 1'b0;
  endtask

  task automatic write_cfg(logic [7:0] index, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_register(index, data);
  endtask

  task automatic configure(logic [7:0] a, logic [7:0] b);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_cfg(REG_SEPARATOR_A, a);
    write_cfg(REG_SEPARATOR_B, b);
    write_cfg(8'($urandom_range(2, 255)), 8'($urandom_range(255)));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] directed[];
    logic [7:0] sep_a_table[8];
    logic [7:0] sep_b_table[8];
    int target;

    directed = '{8'h00, ",", 8'hFF, CR_BYTE, LF_BYTE, LF_BYTE,
                 QUOTE_BYTE, ",", QUOTE_BYTE, QUOTE_BYTE, QUOTE_BYTE, ",",
                 QUOTE_BYTE, "q", QUOTE_BYTE, "z", ",", CR_BYTE,
                 "k", QUOTE_BYTE, "m", LF_BYTE, "e"};
    sep_a_table = '{8'd44, 8'd0, 8'd255, 8'd34, 8'd13, 8'd59, 8'd9, 8'd44};
    sep_b_table = '{8'd44, 8'd0, 8'd255, 8'd34, 8'd10, 8'd44, 8'd124, 8'd13};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) add_text(directed[i], 1'b0);
    add_text(8'($urandom_range(255)), 1'b1);
    add_text(8'($urandom_range(255)), 1'b1);
    run_queue();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 4) begin
        send_idle_pct = 82;
        recv_idle_pct = 31;
      end else if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p < 8) configure(sep_a_table[p], sep_b_table[p]);
      else configure(8'($urandom_range(255)), 8'($urandom_range(255)));
      // A line of 250 to 300 separators, which can drive the field index into saturation.
      if (p == 6) begin
        repeat ($urandom_range(250, 300)) begin
          if ($urandom_range(3) == 0) add_text(plain_byte(), 1'b0);
          add_text(pick_sep(), 1'b0);
        end
        add_text(LF_BYTE, 1'b0);
      end
      target = stim_q.size() + PHASE_ITEMS;
      while (stim_q.size() < target) begin
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 4))
            add_text(8'($urandom_range(255)), $urandom_range(7) == 0);
        end else begin
          add_line();
        end
      end
      if (p == 1 || p == 9) hold_request = 1'b1;
      run_queue();
    end

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
